// ===== rtl/v3a_pkg.sv =====
package v3a_pkg;

    localparam int DATA_W        = 32;
    localparam int PROD_W        = 2 * DATA_W;
    localparam int SUM_W         = PROD_W + 4;
    localparam int KIND_W        = 4;
    localparam int STATUS_W      = 2;
    localparam int LANES         = 3;
    localparam int ITER          = DATA_W;
    localparam int DEPTH         = ITER + 3;
    localparam int FRAC_BITS_DEF = 16;

    localparam logic [KIND_W-1:0] K_ADD   = 4'd0;
    localparam logic [KIND_W-1:0] K_SUB   = 4'd1;
    localparam logic [KIND_W-1:0] K_NEG   = 4'd2;
    localparam logic [KIND_W-1:0] K_SCALE = 4'd3;
    localparam logic [KIND_W-1:0] K_DIV   = 4'd4;
    localparam logic [KIND_W-1:0] K_DOT   = 4'd5;
    localparam logic [KIND_W-1:0] K_CROSS = 4'd6;
    localparam logic [KIND_W-1:0] K_NORM  = 4'd7;
    localparam logic [KIND_W-1:0] K_EQ    = 4'd8;
    localparam logic [KIND_W-1:0] K_NE    = 4'd9;
    localparam logic [KIND_W-1:0] K_LT    = 4'd10;
    localparam logic [KIND_W-1:0] K_GT    = 4'd11;
    localparam logic [KIND_W-1:0] K_LE    = 4'd12;
    localparam logic [KIND_W-1:0] K_GE    = 4'd13;

    localparam logic [STATUS_W-1:0] ST_OK  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_SAT = 2'd1;
    localparam logic [STATUS_W-1:0] ST_DZ  = 2'd2;

    localparam logic signed [DATA_W-1:0] WORD_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] WORD_MIN = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic signed [SUM_W-1:0]  WIDE_MAX = SUM_W'(WORD_MAX);
    localparam logic signed [SUM_W-1:0]  WIDE_MIN = SUM_W'(WORD_MIN);

    typedef logic signed [DATA_W-1:0] word_t;

    typedef struct packed {
        logic  flag;
        word_t val;
    } sat_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              dz;
        logic              cmp;
        sat_t              dot;
        sat_t              vx;
        sat_t              vy;
        sat_t              vz;
    } early_t;

    function automatic sat_t sat32(input logic signed [SUM_W-1:0] v);
        sat_t r;
        r.flag = 1'b0;
        r.val  = v[DATA_W-1:0];
        if (v > WIDE_MAX)
        begin
            r.flag = 1'b1;
            r.val  = WORD_MAX;
        end
        else if (v < WIDE_MIN)
        begin
            r.flag = 1'b1;
            r.val  = WORD_MIN;
        end
        return r;
    endfunction

endpackage

// ===== rtl/vector3_alu.sv =====
// Pipeline: 32-step divide and square root pipelines, plus multiply, merge and
// output stages, lie between an accepted request and its result.
// Throughput: one request per cycle; the whole pipeline holds while a result
// waits on rsp_ready.
// Reset: rst_n clears the stage valid bits only; datapath registers are not reset.
module vector3_alu #(
    parameter int FRAC_BITS = v3a_pkg::FRAC_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               req_valid,
    output logic                               req_ready,
    input  logic [v3a_pkg::KIND_W-1:0]         kind,
    input  logic signed [v3a_pkg::DATA_W-1:0]  a_x,
    input  logic signed [v3a_pkg::DATA_W-1:0]  a_y,
    input  logic signed [v3a_pkg::DATA_W-1:0]  a_z,
    input  logic signed [v3a_pkg::DATA_W-1:0]  b_x,
    input  logic signed [v3a_pkg::DATA_W-1:0]  b_y,
    input  logic signed [v3a_pkg::DATA_W-1:0]  b_z,
    input  logic signed [v3a_pkg::DATA_W-1:0]  scalar_in,
    output logic                               rsp_valid,
    input  logic                               rsp_ready,
    output logic signed [v3a_pkg::DATA_W-1:0]  r_x,
    output logic signed [v3a_pkg::DATA_W-1:0]  r_y,
    output logic signed [v3a_pkg::DATA_W-1:0]  r_z,
    output logic signed [v3a_pkg::DATA_W-1:0]  scalar_out,
    output logic                               compare_true,
    output logic [v3a_pkg::STATUS_W-1:0]       status
);
    import v3a_pkg::*;

    logic                     en;
    logic [DEPTH:1]           v_reg, v_next;
    word_t                    av [LANES];
    word_t                    bv [LANES];
    logic signed [PROD_W-1:0] p0 [LANES];
    logic signed [PROD_W-1:0] p1 [LANES];
    sat_t                     vec [LANES];
    sat_t                     quo [LANES];

    assign en        = !v_reg[DEPTH] || rsp_ready;
    assign req_ready = en;
    assign rsp_valid = v_reg[DEPTH];
    assign v_next    = {v_reg[DEPTH-1:1], req_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= v_next;
        end
    end

    assign av[0] = a_x;
    assign av[1] = a_y;
    assign av[2] = a_z;
    assign bv[0] = b_x;
    assign bv[1] = b_y;
    assign bv[2] = b_z;

    for (genvar l = 0; l < LANES; l++)
    begin : g_lane
        v3a_lane #(
            .FRAC_BITS(FRAC_BITS)
        ) u_lane (
            .clk  (clk),
            .en   (en),
            .kind (kind),
            .a_i  (av[l]),
            .a_j  (av[(l + 1) % LANES]),
            .a_k  (av[(l + 2) % LANES]),
            .b_i  (bv[l]),
            .b_j  (bv[(l + 1) % LANES]),
            .b_k  (bv[(l + 2) % LANES]),
            .s    (scalar_in),
            .p0   (p0[l]),
            .p1   (p1[l]),
            .vec  (vec[l]),
            .quo  (quo[l])
        );
    end

    v3a_merge #(
        .FRAC_BITS(FRAC_BITS)
    ) u_merge (
        .clk          (clk),
        .en           (en),
        .kind         (kind),
        .a_x          (a_x),
        .a_y          (a_y),
        .a_z          (a_z),
        .b_x          (b_x),
        .b_y          (b_y),
        .b_z          (b_z),
        .scalar_in    (scalar_in),
        .p0           (p0),
        .p1           (p1),
        .vec          (vec),
        .quo          (quo),
        .r_x          (r_x),
        .r_y          (r_y),
        .r_z          (r_z),
        .scalar_out   (scalar_out),
        .compare_true (compare_true),
        .status       (status)
    );

endmodule

// ===== rtl/v3a_div.sv =====
module v3a_div #(
    parameter int NW = v3a_pkg::DATA_W + v3a_pkg::FRAC_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        en,
    input  logic [NW-1:0]               n,
    input  logic [v3a_pkg::DATA_W-1:0]  d,
    input  logic                        neg_in,
    output logic [v3a_pkg::DATA_W-1:0]  q,
    output logic                        ovf,
    output logic                        neg
);
    import v3a_pkg::*;

    localparam int CW = NW + DATA_W;

    logic [NW-1:0]     rem_reg [0:ITER-1];
    logic [DATA_W-1:0] d_reg   [0:ITER-1];
    logic [DATA_W-1:0] q_reg   [0:ITER];
    logic              ovf_reg [0:ITER];
    logic              neg_reg [0:ITER];
    logic              ovf_next;

    assign ovf_next = CW'(n) >= (CW'(d) << DATA_W);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= n;
            d_reg[0]   <= d;
            q_reg[0]   <= '0;
            ovf_reg[0] <= ovf_next;
            neg_reg[0] <= neg_in;
        end
    end

    for (genvar t = 0; t < ITER; t++)
    begin : g_step
        localparam int SH = ITER - 1 - t;
        logic [CW-1:0] trial;
        logic          take;

        assign trial = CW'(d_reg[t]) << SH;
        assign take  = CW'(rem_reg[t]) >= trial;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                q_reg[t+1]   <= {q_reg[t][DATA_W-2:0], take};
                ovf_reg[t+1] <= ovf_reg[t];
                neg_reg[t+1] <= neg_reg[t];
            end
        end

        if (t < ITER - 1)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[t+1] <= take ? NW'(CW'(rem_reg[t]) - trial) : rem_reg[t];
                    d_reg[t+1]   <= d_reg[t];
                end
            end
        end
    end

    assign q   = q_reg[ITER];
    assign ovf = ovf_reg[ITER];
    assign neg = neg_reg[ITER];

endmodule

// ===== rtl/v3a_sqrt.sv =====
module v3a_sqrt (
    input  logic                        clk,
    input  logic                        en,
    input  logic [v3a_pkg::PROD_W-1:0]  v,
    output logic [v3a_pkg::DATA_W-1:0]  root
);
    import v3a_pkg::*;

    localparam int CW = PROD_W + 1;

    logic [PROD_W-1:0] rem_reg  [0:ITER-2];
    logic [DATA_W-1:0] root_reg [0:ITER-1];
    logic [PROD_W-1:0] rem_w    [0:ITER-1];
    logic [DATA_W-1:0] root_w   [0:ITER-1];

    assign rem_w[0]  = v;
    assign root_w[0] = '0;

    for (genvar t = 0; t < ITER; t++)
    begin : g_step
        localparam int SH = ITER - 1 - t;
        logic [CW-1:0] trial;
        logic          take;

        assign trial = (CW'(root_w[t]) << (SH + 1)) | (CW'(1) << (2 * SH));
        assign take  = CW'(rem_w[t]) >= trial;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                root_reg[t] <= take ? (root_w[t] | (DATA_W'(1) << SH)) : root_w[t];
            end
        end

        if (t < ITER - 1)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[t] <= take ? PROD_W'(CW'(rem_w[t]) - trial) : rem_w[t];
                end
            end
            assign rem_w[t+1]  = rem_reg[t];
            assign root_w[t+1] = root_reg[t];
        end
    end

    assign root = root_reg[ITER-1];

endmodule

// ===== rtl/v3a_lane.sv =====
module v3a_lane #(
    parameter int FRAC_BITS = v3a_pkg::FRAC_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               en,
    input  logic [v3a_pkg::KIND_W-1:0]         kind,
    input  logic signed [v3a_pkg::DATA_W-1:0]  a_i,
    input  logic signed [v3a_pkg::DATA_W-1:0]  a_j,
    input  logic signed [v3a_pkg::DATA_W-1:0]  a_k,
    input  logic signed [v3a_pkg::DATA_W-1:0]  b_i,
    input  logic signed [v3a_pkg::DATA_W-1:0]  b_j,
    input  logic signed [v3a_pkg::DATA_W-1:0]  b_k,
    input  logic signed [v3a_pkg::DATA_W-1:0]  s,
    output logic signed [v3a_pkg::PROD_W-1:0]  p0,
    output logic signed [v3a_pkg::PROD_W-1:0]  p1,
    output v3a_pkg::sat_t                      vec,
    output v3a_pkg::sat_t                      quo
);
    import v3a_pkg::*;

    localparam int NW = DATA_W + FRAC_BITS;

    word_t                     m0a, m0b, m1a, m1b;
    logic signed [DATA_W:0]    arith_next;
    logic [KIND_W-1:0]         kind1_reg;
    logic signed [PROD_W-1:0]  p0_reg, p1_reg;
    logic signed [DATA_W:0]    arith_reg;
    logic [DATA_W-1:0]         abs_a, abs_s;
    logic [NW-1:0]             div_n;
    logic                      div_neg;
    logic [DATA_W-1:0]         q_mag;
    logic                      q_ovf, q_neg;
    logic signed [DATA_W:0]    q_signed;
    sat_t                      quo_next, quo_reg;

    always_comb
    begin
        m0a        = a_i;
        m0b        = a_i;
        m1a        = b_i;
        m1b        = b_i;
        arith_next = '0;
        unique case (kind)
            K_ADD:   arith_next = (DATA_W+1)'(a_i) + (DATA_W+1)'(b_i);
            K_SUB:   arith_next = (DATA_W+1)'(a_i) - (DATA_W+1)'(b_i);
            K_NEG:   arith_next = -(DATA_W+1)'(a_i);
            K_SCALE: m0b = s;
            K_DOT:   m0b = b_i;
            K_CROSS:
            begin
                m0a = a_j;
                m0b = b_k;
                m1a = a_k;
                m1b = b_j;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            kind1_reg <= kind;
            p0_reg    <= m0a * m0b;
            p1_reg    <= m1a * m1b;
            arith_reg <= arith_next;
        end
    end

    assign p0 = p0_reg;
    assign p1 = p1_reg;

    always_comb
    begin
        unique case (kind1_reg)
            K_ADD, K_SUB, K_NEG: vec = sat32(SUM_W'(arith_reg));
            K_SCALE:             vec = sat32(SUM_W'(p0_reg >>> FRAC_BITS));
            K_CROSS:             vec = sat32((SUM_W'(p0_reg) - SUM_W'(p1_reg)) >>> FRAC_BITS);
            default:             vec = '0;
        endcase
    end

    assign abs_a   = a_i[DATA_W-1] ? -a_i : a_i;
    assign abs_s   = s[DATA_W-1] ? -s : s;
    assign div_n   = {abs_a, {FRAC_BITS{1'b0}}};
    assign div_neg = a_i[DATA_W-1] ^ s[DATA_W-1];

    v3a_div #(
        .NW(NW)
    ) u_div (
        .clk    (clk),
        .en     (en),
        .n      (div_n),
        .d      (abs_s),
        .neg_in (div_neg),
        .q      (q_mag),
        .ovf    (q_ovf),
        .neg    (q_neg)
    );

    assign q_signed = q_neg ? -$signed({1'b0, q_mag}) : $signed({1'b0, q_mag});

    always_comb
    begin
        if (q_ovf)
        begin
            quo_next.flag = 1'b1;
            quo_next.val  = q_neg ? WORD_MIN : WORD_MAX;
        end
        else
        begin
            quo_next = sat32(SUM_W'(q_signed));
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            quo_reg <= quo_next;
        end
    end

    assign quo = quo_reg;

endmodule

// ===== rtl/v3a_merge.sv =====
module v3a_merge #(
    parameter int FRAC_BITS = v3a_pkg::FRAC_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               en,
    input  logic [v3a_pkg::KIND_W-1:0]         kind,
    input  logic signed [v3a_pkg::DATA_W-1:0]  a_x,
    input  logic signed [v3a_pkg::DATA_W-1:0]  a_y,
    input  logic signed [v3a_pkg::DATA_W-1:0]  a_z,
    input  logic signed [v3a_pkg::DATA_W-1:0]  b_x,
    input  logic signed [v3a_pkg::DATA_W-1:0]  b_y,
    input  logic signed [v3a_pkg::DATA_W-1:0]  b_z,
    input  logic signed [v3a_pkg::DATA_W-1:0]  scalar_in,
    input  logic signed [v3a_pkg::PROD_W-1:0]  p0 [v3a_pkg::LANES],
    input  logic signed [v3a_pkg::PROD_W-1:0]  p1 [v3a_pkg::LANES],
    input  v3a_pkg::sat_t                      vec [v3a_pkg::LANES],
    input  v3a_pkg::sat_t                      quo [v3a_pkg::LANES],
    output logic signed [v3a_pkg::DATA_W-1:0]  r_x,
    output logic signed [v3a_pkg::DATA_W-1:0]  r_y,
    output logic signed [v3a_pkg::DATA_W-1:0]  r_z,
    output logic signed [v3a_pkg::DATA_W-1:0]  scalar_out,
    output logic                               compare_true,
    output logic [v3a_pkg::STATUS_W-1:0]       status
);
    import v3a_pkg::*;

    logic [KIND_W-1:0]        kind1_reg;
    logic                     eq1_reg, dz1_reg;
    logic signed [SUM_W-1:0]  dot_sum, sqa_sum, sqb_sum;
    logic [PROD_W-1:0]        sqa, sqb;
    logic                     cmp_next;
    early_t                   early_next;
    early_t                   early_reg [0:ITER];
    logic [PROD_W-1:0]        sqa_reg;
    logic [DATA_W-1:0]        root;
    early_t                   fin;
    word_t                    rx_next, ry_next, rz_next, sc_next;
    logic                     cmp_out_next, sat_next;
    logic [STATUS_W-1:0]      status_next;
    word_t                    rx_reg, ry_reg, rz_reg, sc_reg;
    logic                     cmp_reg;
    logic [STATUS_W-1:0]      status_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            kind1_reg <= kind;
            eq1_reg   <= (a_x == b_x) && (a_y == b_y) && (a_z == b_z);
            dz1_reg   <= (kind == K_DIV) && (scalar_in == '0);
        end
    end

    assign dot_sum = SUM_W'(p0[0]) + SUM_W'(p0[1]) + SUM_W'(p0[2]);
    assign sqa_sum = SUM_W'(p0[0]) + SUM_W'(p0[1]) + SUM_W'(p0[2]);
    assign sqb_sum = SUM_W'(p1[0]) + SUM_W'(p1[1]) + SUM_W'(p1[2]);
    assign sqa     = sqa_sum[PROD_W-1:0];
    assign sqb     = sqb_sum[PROD_W-1:0];

    always_comb
    begin
        unique case (kind1_reg)
            K_EQ:    cmp_next = eq1_reg;
            K_NE:    cmp_next = !eq1_reg;
            K_LT:    cmp_next = sqa < sqb;
            K_GT:    cmp_next = sqa > sqb;
            K_LE:    cmp_next = sqa <= sqb;
            K_GE:    cmp_next = sqa >= sqb;
            default: cmp_next = 1'b0;
        endcase
    end

    always_comb
    begin
        early_next.kind = kind1_reg;
        early_next.dz   = dz1_reg;
        early_next.cmp  = cmp_next;
        early_next.dot  = (kind1_reg == K_DOT) ? sat32(dot_sum >>> FRAC_BITS) : '0;
        early_next.vx   = vec[0];
        early_next.vy   = vec[1];
        early_next.vz   = vec[2];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            early_reg[0] <= early_next;
            sqa_reg      <= sqa;
            for (int k = 1; k <= ITER; k++)
            begin
                early_reg[k] <= early_reg[k-1];
            end
        end
    end

    v3a_sqrt u_sqrt (
        .clk  (clk),
        .en   (en),
        .v    (sqa_reg),
        .root (root)
    );

    assign fin = early_reg[ITER];

    always_comb
    begin
        rx_next      = '0;
        ry_next      = '0;
        rz_next      = '0;
        sc_next      = '0;
        cmp_out_next = 1'b0;
        sat_next     = 1'b0;
        unique case (fin.kind)
            K_ADD, K_SUB, K_NEG, K_SCALE, K_CROSS:
            begin
                rx_next  = fin.vx.val;
                ry_next  = fin.vy.val;
                rz_next  = fin.vz.val;
                sat_next = fin.vx.flag | fin.vy.flag | fin.vz.flag;
            end
            K_DIV:
            begin
                if (!fin.dz)
                begin
                    rx_next  = quo[0].val;
                    ry_next  = quo[1].val;
                    rz_next  = quo[2].val;
                    sat_next = quo[0].flag | quo[1].flag | quo[2].flag;
                end
            end
            K_DOT:
            begin
                sc_next  = fin.dot.val;
                sat_next = fin.dot.flag;
            end
            K_NORM:
            begin
                sat_next = root[DATA_W-1];
                sc_next  = root[DATA_W-1] ? WORD_MAX : root;
            end
            K_EQ, K_NE, K_LT, K_GT, K_LE, K_GE: cmp_out_next = fin.cmp;
            default: ;
        endcase
    end

    always_comb
    begin
        priority if (fin.dz)
            status_next = ST_DZ;
        else if (sat_next)
            status_next = ST_SAT;
        else
            status_next = ST_OK;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rx_reg     <= rx_next;
            ry_reg     <= ry_next;
            rz_reg     <= rz_next;
            sc_reg     <= sc_next;
            cmp_reg    <= cmp_out_next;
            status_reg <= status_next;
        end
    end

    assign r_x          = rx_reg;
    assign r_y          = ry_reg;
    assign r_z          = rz_reg;
    assign scalar_out   = sc_reg;
    assign compare_true = cmp_reg;
    assign status       = status_reg;

endmodule

// ===== rtl/v3a_checker.sv =====
module v3a_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               req_ready,
    input  logic                               rsp_valid,
    input  logic                               rsp_ready,
    input  logic signed [v3a_pkg::DATA_W-1:0]  r_x,
    input  logic signed [v3a_pkg::DATA_W-1:0]  r_y,
    input  logic signed [v3a_pkg::DATA_W-1:0]  r_z,
    input  logic signed [v3a_pkg::DATA_W-1:0]  scalar_out,
    input  logic                               compare_true,
    input  logic [v3a_pkg::STATUS_W-1:0]       status
);
    import v3a_pkg::*;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(r_x) && $stable(r_y)
            && $stable(r_z) && $stable(scalar_out) && $stable(status))
        else $error("result changed while stalled");

    a_free: assert property (@(posedge clk) disable iff (!rst_n)
        !rsp_valid |-> req_ready)
        else $error("request blocked with no result pending");

    a_cmp: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && compare_true |-> r_x == '0 && r_y == '0 && r_z == '0
            && scalar_out == '0 && status == ST_OK)
        else $error("comparison result carries data");

    a_dz: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status == ST_DZ |-> r_x == '0 && r_y == '0 && r_z == '0
            && scalar_out == '0 && !compare_true)
        else $error("divide by zero result not cleared");

endmodule

bind vector3_alu v3a_checker u_v3a_checker (.*);
